// ===== hw/rtl/dtq_pkg.sv =====
// dtq_pkg: shared types, sizes and codes of the deadline timer queue.
// Used by the timer queue top level and its checker; no dependencies.

package dtq_pkg;

  // queue size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CH_W        = IDX_W + 2;

  // word field widths
  localparam int TIME_W     = 48;
  localparam int ID_W       = 8;
  localparam int DELAY_W    = 32;
  localparam int PEND_W     = 5;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = ID_W + DELAY_W;
  localparam int OUT_DATA_W = 16;

  // at most this many fired words per tick
  localparam int MAX_OUT = 16;
  localparam int NOUT_W  = $clog2(MAX_OUT + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // request selector on s_tuser
  localparam logic REQ_SCHED = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result kind on m_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  // one heap entry
  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [ID_W-1:0]   tid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_RD,
    ST_SU_CMP,
    ST_SCH_OUT,
    ST_TK_RD,
    ST_TK_TEST,
    ST_POP_LOAD,
    ST_SD_RD,
    ST_SD_CMP
  } state_t;

  // a leaves the heap before b: earlier deadline, then lower id
  function automatic logic earlier(entry_t a, entry_t b);
    if (a.dl != b.dl) begin
      return a.dl < b.dl;
    end
    return a.tid < b.tid;
  endfunction

endpackage

// ===== hw/rtl/deadline_timer_queue.sv =====
// deadline_timer_queue: min-heap timer queue ordered by deadline.
// Depends on dtq_pkg and dtq_ram.
//
//  channel | dir | tvalid/tready | tdata                         | tuser        | tlast
//  s_      | in  | request word  | [7:0] task_id, [39:8] delay_us| [0] req_type | -
//  m_      | out | result word   | [7:0] fired_id, [12:8] pending| [1:0] kind   | last
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Schedule: an accepted entry sifts up k heap levels, each through ST_SU_RD and
// ST_SU_CMP (k <= log2 QUEUE_DEPTH), then ST_SCH_OUT emits the answer.
// Tick: ST_TK_RD and ST_TK_TEST test the root; each fired task is popped via
// ST_POP_LOAD and sifted down through ST_SD_RD and ST_SD_CMP per level descended,
// except the task that empties the queue; the heap RAM reads are registered.
// Reset (rst, synchronous) empties the queue and clears time; no RAM sweep.
// A result waits in the output register while the next request is taken;
// the sequencer stalls only when it must emit and that register is full.

module deadline_timer_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dtq_pkg::IN_DATA_W-1:0]   s_tdata,   // task_id, delay_us
  input  logic [0:0]                      s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dtq_pkg::OUT_DATA_W-1:0]  m_tdata,   // fired_id, pending, zero pad
  output logic [dtq_pkg::KIND_W-1:0]      m_tuser,   // result_kind
  output logic                            m_tlast    // last
);

  // control state
  dtq_pkg::state_t                 state, state_next;
  logic [dtq_pkg::CNT_W-1:0]       count, count_next;
  logic [dtq_pkg::TIME_W-1:0]      now_us, now_us_next;
  logic [dtq_pkg::NOUT_W-1:0]      n_fired, n_fired_next;
  logic                            held, held_next;
  logic                            out_valid, out_valid_next;

  // payload
  dtq_pkg::entry_t                 ent, ent_next;
  logic [dtq_pkg::IDX_W-1:0]       idx, idx_next;
  logic                            rej, rej_next;
  logic [dtq_pkg::ID_W-1:0]        held_id, held_id_next;
  logic [dtq_pkg::PEND_W-1:0]      held_pend, held_pend_next;
  dtq_pkg::kind_t                  out_kind, out_kind_next;
  logic [dtq_pkg::ID_W-1:0]        out_id, out_id_next;
  logic [dtq_pkg::PEND_W-1:0]      out_pend, out_pend_next;
  logic                            out_last, out_last_next;

  // heap RAM ports
  logic                            we;
  logic [dtq_pkg::IDX_W-1:0]       waddr, raddr_a, raddr_b;
  dtq_pkg::entry_t                 wdata;
  logic [dtq_pkg::ENTRY_W-1:0]     rdata_a, rdata_b;
  dtq_pkg::entry_t                 rd_a, rd_b;

  // helpers
  logic                            out_free;
  logic [dtq_pkg::TIME_W:0]        dl_sum;
  logic [dtq_pkg::TIME_W-1:0]      dl_new;
  logic [dtq_pkg::IDX_W-1:0]       par;
  logic [dtq_pkg::CH_W-1:0]        lch, rch;
  logic                            lv, rv, go_l, go_r, due;
  dtq_pkg::entry_t                 cand;

  dtq_ram #(
    .WIDTH (dtq_pkg::ENTRY_W),
    .DEPTH (dtq_pkg::QUEUE_DEPTH)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign rd_a = dtq_pkg::entry_t'(rdata_a);
  assign rd_b = dtq_pkg::entry_t'(rdata_b);

  // ports
  assign s_tready = (state == dtq_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = dtq_pkg::OUT_DATA_W'({out_pend, out_id});
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign out_free = !out_valid || m_tready;

  // saturating deadline
  assign dl_sum = {1'b0, now_us}
                  + (dtq_pkg::TIME_W + 1)'(s_tdata[dtq_pkg::IN_DATA_W-1:dtq_pkg::ID_W]);
  assign dl_new = dl_sum[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX : dl_sum[dtq_pkg::TIME_W-1:0];

  // heap navigation
  assign par = dtq_pkg::IDX_W'((idx - 1'b1) >> 1);
  assign lch = dtq_pkg::CH_W'({idx, 1'b1});
  assign rch = lch + 1'b1;
  assign lv  = lch < dtq_pkg::CH_W'(count);
  assign rv  = rch < dtq_pkg::CH_W'(count);
  assign go_l = lv && dtq_pkg::earlier(rd_a, ent);
  assign cand = go_l ? rd_a : ent;
  assign go_r = rv && dtq_pkg::earlier(rd_b, cand);

  // root due on this tick and room left in this tick's answer
  assign due = (count != '0) && (n_fired != dtq_pkg::NOUT_W'(dtq_pkg::MAX_OUT))
               && (rd_a.dl <= now_us);

  // sequencer: next state, RAM access and output word
  always_comb begin
    state_next     = state;
    count_next     = count;
    now_us_next    = now_us;
    n_fired_next   = n_fired;
    held_next      = held;
    ent_next       = ent;
    idx_next       = idx;
    rej_next       = rej;
    held_id_next   = held_id;
    held_pend_next = held_pend;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_id_next    = out_id;
    out_pend_next  = out_pend;
    out_last_next  = out_last;
    we             = 1'b0;
    waddr          = idx;
    wdata          = ent;
    raddr_a        = '0;
    raddr_b        = '0;

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      dtq_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == dtq_pkg::REQ_TICK) begin
            if (now_us != dtq_pkg::TIME_MAX) begin
              now_us_next = now_us + 1'b1;
            end
            n_fired_next = '0;
            held_next    = 1'b0;
            state_next   = dtq_pkg::ST_TK_RD;
          end else begin
            ent_next.tid = s_tdata[dtq_pkg::ID_W-1:0];
            ent_next.dl  = dl_new;
            if (count == dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH)) begin
              rej_next   = 1'b1;
              state_next = dtq_pkg::ST_SCH_OUT;
            end else begin
              rej_next   = 1'b0;
              idx_next   = dtq_pkg::IDX_W'(count);
              count_next = count + 1'b1;
              state_next = dtq_pkg::ST_SU_RD;
            end
          end
        end
      end

      // sift-up: the hole climbs while the new entry beats its parent
      dtq_pkg::ST_SU_RD: begin
        if (idx == '0) begin
          we         = 1'b1;
          state_next = dtq_pkg::ST_SCH_OUT;
        end else begin
          raddr_a    = par;
          state_next = dtq_pkg::ST_SU_CMP;
        end
      end

      dtq_pkg::ST_SU_CMP: begin
        we = 1'b1;
        if (dtq_pkg::earlier(ent, rd_a)) begin
          wdata      = rd_a;
          idx_next   = par;
          state_next = dtq_pkg::ST_SU_RD;
        end else begin
          state_next = dtq_pkg::ST_SCH_OUT;
        end
      end

      dtq_pkg::ST_SCH_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = rej ? dtq_pkg::KIND_REJECTED : dtq_pkg::KIND_ACCEPTED;
          out_id_next    = ent.tid;
          out_pend_next  = dtq_pkg::PEND_W'(count);
          out_last_next  = 1'b1;
          state_next     = dtq_pkg::ST_IDLE;
        end
      end

      dtq_pkg::ST_TK_RD: begin
        state_next = dtq_pkg::ST_TK_TEST;
      end

      // root check: flush the held word, then pop the root if due
      dtq_pkg::ST_TK_TEST: begin
        if (!held || out_free) begin
          if (held) begin
            out_valid_next = 1'b1;
            out_kind_next  = dtq_pkg::KIND_FIRED;
            out_id_next    = held_id;
            out_pend_next  = held_pend;
            out_last_next  = !due;
          end
          held_next = due;
          if (due) begin
            held_id_next   = rd_a.tid;
            held_pend_next = dtq_pkg::PEND_W'(count - 1'b1);
            count_next     = count - 1'b1;
            n_fired_next   = n_fired + 1'b1;
            if (count != dtq_pkg::CNT_W'(1)) begin
              raddr_a    = dtq_pkg::IDX_W'(count - 1'b1);
              state_next = dtq_pkg::ST_POP_LOAD;
            end else begin
              state_next = dtq_pkg::ST_TK_RD;
            end
          end else begin
            state_next = dtq_pkg::ST_IDLE;
          end
        end
      end

      // last entry moves into the root hole
      dtq_pkg::ST_POP_LOAD: begin
        ent_next   = rd_a;
        idx_next   = '0;
        state_next = dtq_pkg::ST_SD_RD;
      end

      dtq_pkg::ST_SD_RD: begin
        raddr_a    = lch[dtq_pkg::IDX_W-1:0];
        raddr_b    = rch[dtq_pkg::IDX_W-1:0];
        state_next = dtq_pkg::ST_SD_CMP;
      end

      // sift-down: the smaller child moves up into the hole
      dtq_pkg::ST_SD_CMP: begin
        we = 1'b1;
        if (go_r) begin
          wdata      = rd_b;
          idx_next   = rch[dtq_pkg::IDX_W-1:0];
          state_next = dtq_pkg::ST_SD_RD;
        end else if (go_l) begin
          wdata      = rd_a;
          idx_next   = lch[dtq_pkg::IDX_W-1:0];
          state_next = dtq_pkg::ST_SD_RD;
        end else begin
          state_next = dtq_pkg::ST_TK_RD;
        end
      end

      default: begin
        state_next = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtq_pkg::ST_IDLE;
      count     <= '0;
      now_us    <= '0;
      n_fired   <= '0;
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      now_us    <= now_us_next;
      n_fired   <= n_fired_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ent       <= ent_next;
    idx       <= idx_next;
    rej       <= rej_next;
    held_id   <= held_id_next;
    held_pend <= held_pend_next;
    out_kind  <= out_kind_next;
    out_id    <= out_id_next;
    out_pend  <= out_pend_next;
    out_last  <= out_last_next;
  end

endmodule

// ===== hw/rtl/dtq_ram.sv =====
// dtq_ram: generic RAM, one write port and two registered read ports.
// No dependencies.

module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/dtq_check.sv =====
// dtq_check: port-level assertions for the deadline timer queue, bound to it.
// Depends on dtq_pkg.

module dtq_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dtq_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [dtq_pkg::KIND_W-1:0]      m_tuser,
  input logic                            m_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  // a schedule answer is always the only word of its request
  a_sched_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != dtq_pkg::KIND_FIRED) |-> m_tlast)
    else $error("schedule answer without last");

  // a rejection reports a full queue
  a_rej_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dtq_pkg::KIND_REJECTED)
      |-> m_tdata[12:8] == dtq_pkg::PEND_W'(dtq_pkg::QUEUE_DEPTH))
    else $error("rejected while queue not full");

  // one request at a time: ready drops after each accepted word
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // padding bits above pending stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:13] == 3'd0)
    else $error("nonzero padding in result word");

endmodule

bind deadline_timer_queue dtq_check u_dtq_check (.*);
